[src/swmmm_pkg.sv]
// shared constants, types and state codes of the sliding window statistics unit
`timescale 1ns / 1ps

package swmmm_pkg;

    // window and field geometry
    localparam int WINDOW_DEPTH = 100;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int DATA_W       = 32;
    localparam int FILL_W       = 7;
    localparam int SUM_W        = 39;
    localparam int MODE_W       = 2;
    localparam int DIV_CNT_W    = $clog2(SUM_W + 1);
    localparam int OUT_W        = 136;

    // scale mode codes
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET  = 2'd1;

    // saturation limits
    localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_SCAN,
        ST_DRAIN,
        ST_WAIT
    } t_state;

    // divider request and response
    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  dividend;
        logic [FILL_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quotient;
    } t_div_rsp;

endpackage

[src/swmmm_ram.sv]
// window store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module swmmm_ram (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [swmmm_pkg::ADDR_W-1:0]   i_waddr,
    input  logic [swmmm_pkg::DATA_W-1:0]   i_wdata,
    input  logic                           i_re,
    input  logic [swmmm_pkg::ADDR_W-1:0]   i_raddr,
    output logic [swmmm_pkg::DATA_W-1:0]   o_rdata
);

    logic [swmmm_pkg::DATA_W-1:0] r_mem [swmmm_pkg::WINDOW_DEPTH];
    logic [swmmm_pkg::DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/swmmm_div.sv]
// serial restoring divider: signed window sum by unsigned fill count, one bit a cycle
`timescale 1ns / 1ps

module swmmm_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swmmm_pkg::t_div_req   i_req,
    output swmmm_pkg::t_div_rsp   o_rsp
);

    logic                                 r_busy;
    logic                                 r_done;
    logic [swmmm_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [swmmm_pkg::SUM_W-1:0]          r_q;
    logic [swmmm_pkg::FILL_W-1:0]         r_rem;
    logic [swmmm_pkg::FILL_W-1:0]         r_div;
    logic                                 r_neg;

    logic [swmmm_pkg::FILL_W:0]           s_sh;
    logic [swmmm_pkg::FILL_W:0]           s_diff;
    logic                                 s_ge;
    logic [swmmm_pkg::SUM_W-1:0]          s_mag;
    logic [swmmm_pkg::SUM_W-1:0]          s_sq;

    // magnitude of the dividend
    assign s_mag = i_req.dividend[swmmm_pkg::SUM_W-1] ? (~i_req.dividend + 1'b1)
                                                      : i_req.dividend;

    // one restoring step
    assign s_sh   = {r_rem, r_q[swmmm_pkg::SUM_W-1]};
    assign s_diff = s_sh - {1'b0, r_div};
    assign s_ge   = (s_sh >= {1'b0, r_div});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= swmmm_pkg::DIV_CNT_W'(swmmm_pkg::SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == swmmm_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= s_mag;
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_neg <= i_req.dividend[swmmm_pkg::SUM_W-1];
        end else if (r_busy) begin
            r_q   <= {r_q[swmmm_pkg::SUM_W-2:0], s_ge};
            r_rem <= s_ge ? s_diff[swmmm_pkg::FILL_W-1:0] : s_sh[swmmm_pkg::FILL_W-1:0];
        end
    end

    // sign restore, truncation toward zero follows from the magnitude divide
    assign s_sq = r_neg ? (~r_q + 1'b1) : r_q;

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = s_sq[swmmm_pkg::DATA_W-1:0];

endmodule

[src/sliding_window_min_max_mean_unit.sv]
// top level: sequencer, running sum, min/max scan and output register
`timescale 1ns / 1ps

// Sliding window statistics over the last 100 scaled weight samples. Each accepted
// sample is scaled by scale_mode (3 doubles with saturation, other codes pass through),
// written into a 100-entry ring memory, and answered with one result carrying the
// scaled value, the fill count and the window min, max and mean (truncated toward
// zero). The result register loads once the scan and the divider are both done: the
// scan reads one memory entry a cycle through the single read port, and the 39-step
// serial divider is started beside the scan. The next sample is taken the cycle after
// the load. A finished result waits in the output register while the next sample is
// taken; while it is still held there, the load of the following result waits for
// the result stream.

module sliding_window_min_max_mean_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: scale_mode
    input  logic                                i_cfg_we,
    input  logic [swmmm_pkg::MODE_W-1:0]        i_cfg_wdata,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [swmmm_pkg::DATA_W-1:0]        s_axis_tdata,  // [31:0] weight_sample
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] scaled_weight, [38:32] window_fill, [70:39] window_min,
    // [102:71] window_max, [134:103] window_mean, [135] zero
    output logic [swmmm_pkg::OUT_W-1:0]         m_axis_tdata
);

    swmmm_pkg::t_state                  r_state;
    swmmm_pkg::t_state                  n_state;

    logic [swmmm_pkg::MODE_W-1:0]       r_mode;
    logic [swmmm_pkg::ADDR_W-1:0]       r_pos;
    logic [swmmm_pkg::FILL_W-1:0]       r_fill;
    logic signed [swmmm_pkg::SUM_W-1:0] r_sum;
    logic [swmmm_pkg::DATA_W-1:0]       r_scaled;
    logic [swmmm_pkg::ADDR_W-1:0]       r_idx;
    logic                               r_pend;
    logic                               r_pend_first;
    logic [swmmm_pkg::DATA_W-1:0]       r_min;
    logic [swmmm_pkg::DATA_W-1:0]       r_max;
    logic                               r_out_vld;
    logic [swmmm_pkg::OUT_W-1:0]        r_out;

    logic [swmmm_pkg::DATA_W-1:0]       s_scaled;
    logic                               s_in_acc;
    logic                               s_full;
    logic                               s_scan_last;
    logic                               s_out_free;
    logic                               s_mem_we;
    logic                               s_mem_re;
    logic [swmmm_pkg::ADDR_W-1:0]       s_mem_raddr;
    logic [swmmm_pkg::DATA_W-1:0]       s_mem_rdata;
    logic                               s_load_out;
    logic signed [swmmm_pkg::SUM_W-1:0] s_old_ext;
    logic signed [swmmm_pkg::SUM_W-1:0] s_new_ext;

    swmmm_pkg::t_div_req                s_div_req;
    swmmm_pkg::t_div_rsp                s_div_rsp;

    // mode scaling with saturation on doubling
    always_comb begin
        s_scaled = s_axis_tdata;
        if (r_mode == swmmm_pkg::MODE_DOUBLE) begin
            if (s_axis_tdata[31] ^ s_axis_tdata[30]) begin
                s_scaled = s_axis_tdata[31] ? swmmm_pkg::S32_MIN : swmmm_pkg::S32_MAX;
            end else begin
                s_scaled = {s_axis_tdata[30:0], 1'b0};
            end
        end
    end

    assign s_full      = (r_fill == swmmm_pkg::FILL_W'(swmmm_pkg::WINDOW_DEPTH));
    assign s_scan_last = (r_idx == swmmm_pkg::ADDR_W'(r_fill - 1'b1));
    assign s_out_free  = !r_out_vld || m_axis_tready;
    assign s_in_acc    = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swmmm_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = swmmm_pkg::ST_UPD;
            end
            swmmm_pkg::ST_UPD: begin
                n_state = swmmm_pkg::ST_SCAN;
            end
            swmmm_pkg::ST_SCAN: begin
                if (s_scan_last) n_state = swmmm_pkg::ST_DRAIN;
            end
            swmmm_pkg::ST_DRAIN: begin
                n_state = swmmm_pkg::ST_WAIT;
            end
            swmmm_pkg::ST_WAIT: begin
                if (s_div_rsp.done && s_out_free) n_state = swmmm_pkg::ST_IDLE;
            end
            default: begin
                n_state = swmmm_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready      = 1'b0;
        s_mem_re           = 1'b0;
        s_mem_raddr        = r_pos;
        s_mem_we           = 1'b0;
        s_div_req.start    = 1'b0;
        s_div_req.dividend = r_sum;
        s_div_req.divisor  = r_fill;
        s_load_out         = 1'b0;
        case (r_state)
            swmmm_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                s_mem_re      = s_axis_tvalid;
            end
            swmmm_pkg::ST_UPD: begin
                s_mem_we = 1'b1;
            end
            swmmm_pkg::ST_SCAN: begin
                s_mem_re        = 1'b1;
                s_mem_raddr     = r_idx;
                s_div_req.start = (r_idx == '0);
            end
            swmmm_pkg::ST_DRAIN: begin
            end
            swmmm_pkg::ST_WAIT: begin
                s_load_out = s_div_rsp.done && s_out_free;
            end
            default: begin
            end
        endcase
    end

    swmmm_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (s_mem_we),
        .i_waddr (r_pos),
        .i_wdata (r_scaled),
        .i_re    (s_mem_re),
        .i_raddr (s_mem_raddr),
        .o_rdata (s_mem_rdata)
    );

    swmmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_div_req),
        .o_rsp   (s_div_rsp)
    );

    // evicted and incoming values, sign extended to the sum width
    assign s_old_ext = s_full ? swmmm_pkg::SUM_W'($signed(s_mem_rdata)) : '0;
    assign s_new_ext = swmmm_pkg::SUM_W'($signed(r_scaled));

    // state register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swmmm_pkg::ST_IDLE;
            r_mode  <= swmmm_pkg::MODE_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_mode <= i_cfg_wdata;
        end
    end

    // window bookkeeping: position, fill and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (r_state == swmmm_pkg::ST_UPD) begin
            r_sum <= r_sum - s_old_ext + s_new_ext;
            if (r_pos == swmmm_pkg::ADDR_W'(swmmm_pkg::WINDOW_DEPTH - 1)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
            if (!s_full) r_fill <= r_fill + 1'b1;
        end
    end

    // sample capture and scan index
    always_ff @(posedge i_clk) begin
        if (s_in_acc) r_scaled <= s_scaled;
        if (r_state == swmmm_pkg::ST_UPD) begin
            r_idx <= '0;
        end else if (r_state == swmmm_pkg::ST_SCAN) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // read tracking for the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= 1'b0;
            r_pend_first <= 1'b0;
        end else begin
            r_pend       <= (r_state == swmmm_pkg::ST_SCAN);
            r_pend_first <= (r_state == swmmm_pkg::ST_SCAN) && (r_idx == '0);
        end
    end

    // min and max over returned entries
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            if (r_pend_first) begin
                r_min <= s_mem_rdata;
                r_max <= s_mem_rdata;
            end else begin
                if ($signed(s_mem_rdata) < $signed(r_min)) r_min <= s_mem_rdata;
                if ($signed(s_mem_rdata) > $signed(r_max)) r_max <= s_mem_rdata;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_load_out) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load_out) begin
            r_out <= {1'b0, s_div_rsp.quotient, r_max, r_min, r_fill, r_scaled};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    // fill count never passes the window depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= swmmm_pkg::FILL_W'(swmmm_pkg::WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    // write position stays inside the window
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < swmmm_pkg::ADDR_W'(swmmm_pkg::WINDOW_DEPTH))
        else $error("write position outside window");

    // one sample at a time: no new transaction right after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a sample is in work");

    // a presented result has min not above max
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[70:39]) <= $signed(m_axis_tdata[102:71]))
        else $error("window min above window max");
`endif

endmodule

[tb/testbench.sv]
// self-checking testbench for the sliding window min/max/mean unit
`timescale 1ns / 1ps

module testbench;

    // scale mode codes other than the doubling code
    localparam logic [swmmm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd0;
    localparam logic [swmmm_pkg::MODE_W-1:0] MODE_PASS_A = 2'd1;
    localparam logic [swmmm_pkg::MODE_W-1:0] MODE_PASS_B = 2'd2;

    localparam int DIR_ROWS    = 18;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 222;
    localparam int HOLD_CYCLES = 2000;
    localparam int HOLD_AFTER  = 400;
    localparam int PAUSE_PHASE = 2;
    localparam int PAUSE_ITEM  = 100;
    localparam int FULL_RATE   = 3;
    localparam int MAX_SHOWN   = 40;

    // one result transaction, unpacked into fields
    typedef struct packed {
        logic signed [swmmm_pkg::DATA_W-1:0] scaled;
        logic [swmmm_pkg::FILL_W-1:0]        fill;
        logic signed [swmmm_pkg::DATA_W-1:0] lo;
        logic signed [swmmm_pkg::DATA_W-1:0] hi;
        logic signed [swmmm_pkg::DATA_W-1:0] mean;
    } t_stats;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_ALL,
        CHK_SCALED
    } t_row_chk;

    typedef struct packed {
        logic [swmmm_pkg::MODE_W-1:0] mode;
        logic [swmmm_pkg::DATA_W-1:0] weight;
        t_row_chk                     chk;
        t_stats                       known;
    } t_dir_row;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [swmmm_pkg::MODE_W-1:0]   i_cfg_wdata   = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [swmmm_pkg::DATA_W-1:0]   s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [swmmm_pkg::OUT_W-1:0]    m_axis_tdata;

    // window predictor state
    logic signed [swmmm_pkg::DATA_W-1:0] win_vals [swmmm_pkg::WINDOW_DEPTH];
    int                                  win_pos  = 0;
    int                                  win_fill = 0;
    longint                              win_sum  = 0;
    logic [swmmm_pkg::MODE_W-1:0]        cur_mode = swmmm_pkg::MODE_RESET;

    t_stats   expected_q [$];
    t_dir_row dir_rows [DIR_ROWS];
    int       err_count    = 0;
    int       results_seen = 0;
    int       samples_sent = 0;
    int       mode_writes  = 0;
    int       wraps        = 0;
    bit       tx_idle_en   = 1'b1;
    bit       rx_idle_en   = 1'b1;

    sliding_window_min_max_mean_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] weight_sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [31:0] scaled_weight, [38:32] window_fill, [70:39] window_min,
        // [102:71] window_max, [134:103] window_mean
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scale, insert into the ring window and compute min, max and mean
    function automatic t_stats predict_window(logic [swmmm_pkg::DATA_W-1:0] sample);
        t_stats                              r;
        longint                              d;
        logic signed [swmmm_pkg::DATA_W-1:0] s;
        int                                  i;
        s = sample;
        if (cur_mode == swmmm_pkg::MODE_DOUBLE) begin
            d = longint'($signed(sample)) * 2;
            if (d > longint'($signed(swmmm_pkg::S32_MAX)))
                s = swmmm_pkg::S32_MAX;
            else if (d < longint'($signed(swmmm_pkg::S32_MIN)))
                s = swmmm_pkg::S32_MIN;
            else
                s = d[swmmm_pkg::DATA_W-1:0];
        end
        // oldest value drops out once the window is full
        if (win_fill == swmmm_pkg::WINDOW_DEPTH)
            win_sum -= longint'(win_vals[win_pos]);
        win_vals[win_pos] = s;
        win_sum += longint'(s);
        if (win_pos == swmmm_pkg::WINDOW_DEPTH - 1) begin
            win_pos = 0;
            wraps++;
        end else begin
            win_pos++;
        end
        if (win_fill < swmmm_pkg::WINDOW_DEPTH)
            win_fill++;
        r.scaled = s;
        r.fill   = win_fill[swmmm_pkg::FILL_W-1:0];
        r.lo     = win_vals[0];
        r.hi     = win_vals[0];
        for (i = 1; i < win_fill; i++) begin
            if (win_vals[i] < r.lo) r.lo = win_vals[i];
            if (win_vals[i] > r.hi) r.hi = win_vals[i];
        end
        // longint division truncates toward zero
        d      = win_sum / longint'(win_fill);
        r.mean = d[swmmm_pkg::DATA_W-1:0];
        return r;
    endfunction

    // random weight: full range, realistic loads, extremes, doubling edges, magnitudes
    function automatic logic [swmmm_pkg::DATA_W-1:0] pick_weight();
        logic [swmmm_pkg::DATA_W-1:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2: w = $urandom;
            3, 4, 5: w = int'($urandom_range(0, 400000)) - 200000;
            6: begin
                case ($urandom_range(0, 4))
                    0: w = swmmm_pkg::S32_MAX;
                    1: w = swmmm_pkg::S32_MIN;
                    2: w = '0;
                    3: w = '1;
                    default: w = 32'd1;
                endcase
            end
            7: begin
                w = $urandom_range(0, 1) ? 32'h4000_0000 : 32'hc000_0000;
                w = w + $urandom_range(0, 8) - 4;
            end
            default: begin
                w = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    w = ~w;
            end
        endcase
        return w;
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int pick_tx_gap();
        if (!tx_idle_en)
            return 0;
        case ($urandom_range(0, 19))
            12, 13, 14, 15, 16, 17: return $urandom_range(1, 4);
            18: return $urandom_range(5, 30);
            19: return $urandom_range(60, 120);
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [swmmm_pkg::DATA_W-1:0] got,
                                   logic [swmmm_pkg::DATA_W-1:0] want);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("mismatch on result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
    endtask

    // offer one sample and hold it until the transaction completes
    task automatic send_sample(logic [swmmm_pkg::DATA_W-1:0] w, output t_stats pred);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_window(w);
        samples_sent++;
    endtask

    task automatic tx_gap(int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // scale mode write, only issued with the block idle
    task automatic write_mode(logic [swmmm_pkg::MODE_W-1:0] m);
        drain_results();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_mode = m;
        mode_writes++;
    endtask

    // result ready: random stalls, one long hold-off while the sender keeps going
    int  rx_stall  = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else if (!rx_idle_en) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall      <= rx_stall - 1;
        end else begin
            case ($urandom_range(0, 19))
                14, 15, 16, 17: begin
                    m_axis_tready <= 1'b0;
                    rx_stall      <= $urandom_range(0, 4);
                end
                18: begin
                    m_axis_tready <= 1'b0;
                    rx_stall      <= $urandom_range(20, 120);
                end
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_stats got;
        t_stats want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.scaled = m_axis_tdata[31:0];
            got.fill   = m_axis_tdata[38:32];
            got.lo     = m_axis_tdata[70:39];
            got.hi     = m_axis_tdata[102:71];
            got.mean   = m_axis_tdata[134:103];
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, scaled", got.scaled, '0);
            end else begin
                want = expected_q.pop_front();
                if (got.scaled !== want.scaled)
                    report_mismatch("scaled_weight", got.scaled, want.scaled);
                if (got.fill !== want.fill)
                    report_mismatch("window_fill", 32'(got.fill), 32'(want.fill));
                if (got.lo !== want.lo)
                    report_mismatch("window_min", got.lo, want.lo);
                if (got.hi !== want.hi)
                    report_mismatch("window_max", got.hi, want.hi);
                if (got.mean !== want.mean)
                    report_mismatch("window_mean", got.mean, want.mean);
            end
        end
    end

    // stimulus: directed table, then random phases over all scale modes
    initial begin : stimulus
        t_stats                       pred;
        logic [swmmm_pkg::MODE_W-1:0] phase_modes [PHASES];
        int                           r;
        int                           p;
        int                           n;

        dir_rows = '{
            // after reset, both extremes; mean of -1 over two truncates to zero
            '{MODE_PASS_A, 32'h7fff_ffff, CHK_ALL,
              '{32'h7fff_ffff, 7'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}},
            '{MODE_PASS_A, 32'h8000_0000, CHK_ALL,
              '{32'h8000_0000, 7'd2, 32'h8000_0000, 32'h7fff_ffff, 32'h0}},
            '{MODE_PASS_A, 32'h0000_0000, CHK_MODEL, '0},
            '{MODE_PASS_A, 32'hffff_ffff, CHK_MODEL, '0},
            '{MODE_PASS_A, 32'h0000_0001, CHK_MODEL, '0},
            // doubling, with saturation on both sides and exact edges
            '{swmmm_pkg::MODE_DOUBLE, 32'h4000_0000, CHK_SCALED,
              '{32'h7fff_ffff, '0, '0, '0, '0}},
            '{swmmm_pkg::MODE_DOUBLE, 32'hbfff_ffff, CHK_SCALED,
              '{32'h8000_0000, '0, '0, '0, '0}},
            '{swmmm_pkg::MODE_DOUBLE, 32'h3fff_ffff, CHK_SCALED,
              '{32'h7fff_fffe, '0, '0, '0, '0}},
            '{swmmm_pkg::MODE_DOUBLE, 32'hc000_0000, CHK_SCALED,
              '{32'h8000_0000, '0, '0, '0, '0}},
            '{swmmm_pkg::MODE_DOUBLE, 32'h8000_0000, CHK_SCALED,
              '{32'h8000_0000, '0, '0, '0, '0}},
            '{swmmm_pkg::MODE_DOUBLE, 32'h7fff_ffff, CHK_SCALED,
              '{32'h7fff_ffff, '0, '0, '0, '0}},
            '{swmmm_pkg::MODE_DOUBLE, 32'hffff_fffd, CHK_SCALED,
              '{32'hffff_fffa, '0, '0, '0, '0}},
            // unused mode code passes the sample through
            '{MODE_UNUSED, 32'h0000_3039, CHK_SCALED, '{32'h0000_3039, '0, '0, '0, '0}},
            '{MODE_UNUSED, 32'h8000_0000, CHK_SCALED, '{32'h8000_0000, '0, '0, '0, '0}},
            '{MODE_PASS_B, 32'h7fff_ffff, CHK_MODEL, '0},
            '{MODE_PASS_B, 32'hffff_ff9c, CHK_MODEL, '0},
            '{MODE_PASS_B, 32'h5555_5555, CHK_MODEL, '0},
            '{MODE_PASS_B, 32'haaaa_aaaa, CHK_MODEL, '0}
        };
        phase_modes = '{swmmm_pkg::MODE_DOUBLE, MODE_PASS_A, MODE_UNUSED, MODE_PASS_B,
                        swmmm_pkg::MODE_DOUBLE, MODE_PASS_A};

        // reset
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(MODE_PASS_A);

        // directed table
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].mode != cur_mode)
                write_mode(dir_rows[r].mode);
            send_sample(dir_rows[r].weight, pred);
            if (dir_rows[r].chk == CHK_ALL)
                pred = dir_rows[r].known;
            else if (dir_rows[r].chk == CHK_SCALED)
                pred.scaled = dir_rows[r].known.scaled;
            expected_q.push_back(pred);
            tx_gap(pick_tx_gap());
        end

        // random phases, one scale mode each; one phase runs both sides at full rate
        for (p = 0; p < PHASES; p++) begin
            write_mode(phase_modes[p]);
            tx_idle_en = (p != FULL_RATE);
            rx_idle_en = (p != FULL_RATE);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == PAUSE_PHASE && n == PAUSE_ITEM)
                    drain_results();
                send_sample(pick_weight(), pred);
                expected_q.push_back(pred);
                tx_gap(pick_tx_gap());
            end
        end

        // let the last results come back, then a margin for stray output
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        drain_results();
        repeat (swmmm_pkg::WINDOW_DEPTH + 20) @(posedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch("results missing, count", expected_q.size(), '0);

        $display("run sent %0d samples through %0d scale mode writes, window wrapped %0d times",
                 samples_sent, mode_writes, wraps);
        $display("%0d results checked, %0d mismatches", results_seen, err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
src/swmmm_pkg.sv
src/swmmm_ram.sv
src/swmmm_div.sv
src/sliding_window_min_max_mean_unit.sv
tb/testbench.sv
